/* rtl/ssa_pkg.sv */
// Shared types and constants of the sample skewness accumulator.
`timescale 1ns / 1ps
package ssa_pkg;

  localparam int MAX_COUNT   = 32768;
  localparam int SAMPLE_BITS = 16;
  localparam int MIN_COUNT   = 3;
  localparam int CNT_W       = 16;
  // Wide enough for n(n-1) * A^2 * 2^46 and for (2q-1)^2 * (n-2)^2 * B^3.
  localparam int W           = 288;
  localparam int Q_W         = 32;
  localparam int BIT_W       = 5;
  localparam int FRAC_SHIFT  = 46;

  typedef enum logic [1:0] {
    ST_VALID = 2'd0,
    ST_FEW   = 2'd1,
    ST_ZVAR  = 2'd2,
    ST_OVF   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    RG_N, RG_S1, RG_S2, RG_S3, RG_T, RG_U, RG_B, RG_A, RG_K, RG_L, RG_R, RG_D
  } reg_e;

  localparam int NREG = 12;

  typedef enum logic [3:0] {
    OP_NOP, OP_LDK, OP_MUL, OP_ADD, OP_SUB, OP_ABS, OP_TESTB, OP_QTEST, OP_OUT
  } op_e;

  typedef enum logic [3:0] {
    K_CNT, K_S1, K_S2, K_S3, K_3N, K_NM1, K_NM2, K_P46, K_D
  } ksel_e;

  typedef struct packed {
    op_e   op;
    reg_e  dst;
    reg_e  sa;
    reg_e  sb;
    ksel_e ksel;
  } instr_t;

  typedef struct packed {
    logic             start;
    instr_t           ins;
    logic [BIT_W-1:0] bitpos;
    status_e          status;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic bnp;
    logic ovf;
    logic few;
    logic out_full;
  } stat_t;

endpackage

/* rtl/ssa_in_if.sv */
// Input channel: one sample word with its end-of-group flag.
`timescale 1ns / 1ps
interface ssa_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample;
  logic        last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

/* rtl/ssa_out_if.sv */
// Output channel: one skewness word with its status.
`timescale 1ns / 1ps
interface ssa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] skewness;
  logic [1:0]  status;

  modport source (output valid, output skewness, output status, input ready);
  modport sink   (input valid, input skewness, input status, output ready);
endinterface

/* rtl/sample_skewness_accumulator.sv */
// Top level of the adjusted sample skewness accumulator.
`timescale 1ns / 1ps
// Throughput: a sample word that does not end its group is taken every cycle while no
// group is being finished; the squares and cubes run through a two-stage accumulate
// pipe behind the input. After a group's last word the controller skips the finishing
// program when the group has too few samples or the count overflowed; otherwise the
// program uses the bit-serial wide multiplier 15 times plus 64 times in the 32-step
// rounding search (one shift-add per bit of the second operand).
// Reset (asynchronous, active low) clears the count, the sums and all control state.
module sample_skewness_accumulator
  import ssa_pkg::*;
(
  input logic   clk_i,
  input logic   rst_ni,
  ssa_in_if.sink    in_i,
  ssa_out_if.source out_o
);

  // A word is taken when valid meets ready; the controller holds ready high
  // whenever no group is being finished; finishing a group waits on a full output.
  logic  accept;
  logic  ready;
  cmd_t  cmd;
  stat_t stat;

  assign accept     = in_i.valid && ready;
  assign in_i.ready = ready;

  // The controller walks the finishing program and waits on the datapath.
  ssa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (accept),
    .in_last_i   (in_i.last),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_ready_o  (ready)
  );

  // The datapath keeps the running sums, the wide working values and the
  // result register, which parts the finishing logic from the output side.
  ssa_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .in_accept_i    (accept),
    .in_sample_i    (in_i.sample),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .out_skewness_o (out_o.skewness),
    .out_status_o   (out_o.status)
  );

endmodule

/* rtl/ssa_dp.sv */
// Datapath: accumulators, wide register memory, shift-add multiplier, result register.
`timescale 1ns / 1ps
module ssa_dp
  import ssa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  input  logic        in_accept_i,
  input  logic [15:0] in_sample_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [31:0] out_skewness_o,
  output logic [1:0]  out_status_o
);

  localparam int SHIFT = 16 - SAMPLE_BITS;

  typedef enum logic [1:0] {PH_IDLE, PH_EXE, PH_MUL} phase_e;

  phase_e             phase_q;
  cmd_t               cmd_q;
  logic               done_q, bnp_q, neg_q, ovf_q, pend_q, out_valid_q;
  logic [Q_W-1:0]     q_q;
  logic [CNT_W-1:0]   count_q;
  logic [31:0]        sum_x_q;
  logic [47:0]        sum_x2_q;
  logic [63:0]        sum_x3_q;
  logic signed [15:0] x_q;
  logic signed [31:0] x2_q;
  logic [W-1:0]       mem_q [NREG];
  logic [W-1:0]       rd_a_q, rd_b_q, mx_q, my_q, mp_q;
  logic [31:0]        skew_q;
  status_e            status_q;

  logic signed [15:0] xs;
  logic signed [47:0] p3;
  logic [W-1:0]       kval, wr_data;
  logic               wr_en;
  logic [Q_W:0]       cand;
  logic [Q_W+1:0]     dval;
  logic [31:0]        skew_d;

  assign xs   = $signed(in_sample_i << SHIFT) >>> SHIFT;
  assign p3   = x2_q * x_q;
  assign cand = {1'b0, q_q} | ((Q_W + 1)'(1) << cmd_q.bitpos);
  assign dval = {cand, 1'b0} - (Q_W + 2)'(1);

  always_comb begin
    case (cmd_q.ins.ksel)
      K_CNT:   kval = W'(count_q);
      K_S1:    kval = {{(W - 32){sum_x_q[31]}}, sum_x_q};
      K_S2:    kval = W'(sum_x2_q);
      K_S3:    kval = {{(W - 64){sum_x3_q[63]}}, sum_x3_q};
      K_3N:    kval = W'({count_q, 1'b0}) + W'(count_q);
      K_NM1:   kval = W'(count_q - CNT_W'(1));
      K_NM2:   kval = W'(count_q - CNT_W'(2));
      K_P46:   kval = W'(1) << FRAC_SHIFT;
      K_D:     kval = W'(dval);
      default: kval = '0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_data = mp_q;
    if (phase_q == PH_EXE) begin
      case (cmd_q.ins.op)
        OP_LDK: begin
          wr_en   = 1'b1;
          wr_data = kval;
        end
        OP_ADD: begin
          wr_en   = 1'b1;
          wr_data = rd_a_q + rd_b_q;
        end
        OP_SUB: begin
          wr_en   = 1'b1;
          wr_data = rd_a_q - rd_b_q;
        end
        OP_ABS: begin
          wr_en   = 1'b1;
          wr_data = rd_a_q[W-1] ? ('0 - rd_a_q) : rd_a_q;
        end
        default: wr_en = 1'b0;
      endcase
    end else if (phase_q == PH_MUL && my_q == '0) begin
      wr_en = 1'b1;
    end
  end

  // Round-half-up search gives the magnitude; apply sign and clamp, or zero if not valid.
  always_comb begin
    if (cmd_q.status != ST_VALID) begin
      skew_d = '0;
    end else if (neg_q) begin
      skew_d = (q_q > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - q_q);
    end else begin
      skew_d = q_q[31] ? 32'h7FFF_FFFF : q_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      done_q      <= 1'b0;
      bnp_q       <= 1'b0;
      neg_q       <= 1'b0;
      ovf_q       <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      q_q         <= '0;
      count_q     <= '0;
      sum_x_q     <= '0;
      sum_x2_q    <= '0;
      sum_x3_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      pend_q <= 1'b0;
      if (in_accept_i) begin
        if (count_q == CNT_W'(MAX_COUNT)) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + CNT_W'(1);
          pend_q  <= 1'b1;
        end
      end
      if (pend_q) begin
        sum_x_q  <= sum_x_q + {{16{x_q[15]}}, x_q};
        sum_x2_q <= sum_x2_q + {16'd0, x2_q};
        sum_x3_q <= sum_x3_q + {{16{p3[47]}}, p3};
      end
      case (phase_q)
        PH_IDLE: begin
          if (cmd_i.start) begin
            phase_q <= PH_EXE;
          end
        end
        PH_EXE: begin
          if (cmd_q.ins.op == OP_MUL) begin
            phase_q <= PH_MUL;
          end else begin
            phase_q <= PH_IDLE;
            done_q  <= 1'b1;
          end
          case (cmd_q.ins.op)
            OP_ABS:   neg_q <= rd_a_q[W-1];
            OP_TESTB: bnp_q <= (rd_a_q == '0) || rd_a_q[W-1];
            OP_QTEST: begin
              if (rd_a_q <= rd_b_q) begin
                q_q <= cand[Q_W-1:0];
              end
            end
            OP_OUT: begin
              out_valid_q <= 1'b1;
              q_q         <= '0;
              count_q     <= '0;
              ovf_q       <= 1'b0;
              sum_x_q     <= '0;
              sum_x2_q    <= '0;
              sum_x3_q    <= '0;
            end
            default: begin
            end
          endcase
        end
        PH_MUL: begin
          if (my_q == '0) begin
            phase_q <= PH_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: phase_q <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      x_q  <= xs;
      x2_q <= xs * xs;
    end
    if (phase_q == PH_IDLE && cmd_i.start) begin
      cmd_q  <= cmd_i;
      rd_a_q <= mem_q[cmd_i.ins.sa];
      rd_b_q <= mem_q[cmd_i.ins.sb];
    end
    if (wr_en) begin
      mem_q[cmd_q.ins.dst] <= wr_data;
    end
    if (phase_q == PH_EXE && cmd_q.ins.op == OP_MUL) begin
      // Multiply by a non-negative operand: flip both signs if needed.
      mx_q <= rd_b_q[W-1] ? ('0 - rd_a_q) : rd_a_q;
      my_q <= rd_b_q[W-1] ? ('0 - rd_b_q) : rd_b_q;
      mp_q <= '0;
    end else if (phase_q == PH_MUL && my_q != '0) begin
      if (my_q[0]) begin
        mp_q <= mp_q + mx_q;
      end
      mx_q <= mx_q << 1;
      my_q <= my_q >> 1;
    end
    if (phase_q == PH_EXE && cmd_q.ins.op == OP_OUT) begin
      skew_q   <= skew_d;
      status_q <= cmd_q.status;
    end
  end

  assign stat_o.done     = done_q;
  assign stat_o.bnp      = bnp_q;
  assign stat_o.ovf      = ovf_q;
  assign stat_o.few      = count_q < CNT_W'(MIN_COUNT);
  assign stat_o.out_full = out_valid_q;

  assign out_valid_o    = out_valid_q;
  assign out_skewness_o = skew_q;
  assign out_status_o   = status_q;

endmodule

/* rtl/ssa_ctrl.sv */
// Controller: input acceptance and the sequencer that runs the finishing program.
`timescale 1ns / 1ps
module ssa_ctrl
  import ssa_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_accept_i,
  input  logic  in_last_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  in_ready_o
);

  typedef enum logic [2:0] {C_IDLE, C_FIN, C_ISSUE, C_WAIT, C_OUTW, C_OUTD} state_e;

  localparam logic [5:0] PC_TESTB = 6'd7;
  localparam logic [5:0] PC_LOOP  = 6'd29;
  localparam logic [5:0] PC_LAST  = 6'd32;

  state_e           state_q;
  cmd_t             cmd_q;
  logic             ready_q;
  logic [5:0]       pc_q;
  logic [BIT_W-1:0] bit_q;
  status_e          res_q;

  function automatic instr_t ins(op_e op, reg_e d, reg_e a, reg_e b, ksel_e k);
    instr_t r;
    r.op   = op;
    r.dst  = d;
    r.sa   = a;
    r.sb   = b;
    r.ksel = k;
    return r;
  endfunction

  // dst = sa * sb iterates over the bits of sb, so sb is the narrower one.
  function automatic instr_t rom(logic [5:0] pc);
    instr_t r;
    case (pc)
      6'd0:  r = ins(OP_LDK,   RG_N,  RG_N,  RG_N,  K_CNT);
      6'd1:  r = ins(OP_LDK,   RG_S1, RG_N,  RG_N,  K_S1);
      6'd2:  r = ins(OP_LDK,   RG_S2, RG_N,  RG_N,  K_S2);
      6'd3:  r = ins(OP_LDK,   RG_S3, RG_N,  RG_N,  K_S3);
      6'd4:  r = ins(OP_MUL,   RG_T,  RG_S2, RG_N,  K_CNT);
      6'd5:  r = ins(OP_MUL,   RG_U,  RG_S1, RG_S1, K_CNT);
      6'd6:  r = ins(OP_SUB,   RG_B,  RG_T,  RG_U,  K_CNT);
      6'd7:  r = ins(OP_TESTB, RG_B,  RG_B,  RG_B,  K_CNT);
      6'd8:  r = ins(OP_MUL,   RG_T,  RG_N,  RG_N,  K_CNT);
      6'd9:  r = ins(OP_MUL,   RG_A,  RG_S3, RG_T,  K_CNT);
      6'd10: r = ins(OP_LDK,   RG_K,  RG_N,  RG_N,  K_3N);
      6'd11: r = ins(OP_MUL,   RG_T,  RG_S1, RG_K,  K_CNT);
      6'd12: r = ins(OP_MUL,   RG_T,  RG_T,  RG_S2, K_CNT);
      6'd13: r = ins(OP_SUB,   RG_A,  RG_A,  RG_T,  K_CNT);
      6'd14: r = ins(OP_MUL,   RG_T,  RG_U,  RG_S1, K_CNT);
      6'd15: r = ins(OP_ADD,   RG_T,  RG_T,  RG_T,  K_CNT);
      6'd16: r = ins(OP_ADD,   RG_A,  RG_A,  RG_T,  K_CNT);
      6'd17: r = ins(OP_ABS,   RG_A,  RG_A,  RG_A,  K_CNT);
      6'd18: r = ins(OP_MUL,   RG_L,  RG_A,  RG_A,  K_CNT);
      6'd19: r = ins(OP_LDK,   RG_K,  RG_N,  RG_N,  K_NM1);
      6'd20: r = ins(OP_MUL,   RG_K,  RG_N,  RG_K,  K_CNT);
      6'd21: r = ins(OP_MUL,   RG_L,  RG_L,  RG_K,  K_CNT);
      6'd22: r = ins(OP_LDK,   RG_K,  RG_N,  RG_N,  K_P46);
      6'd23: r = ins(OP_MUL,   RG_L,  RG_L,  RG_K,  K_CNT);
      6'd24: r = ins(OP_MUL,   RG_R,  RG_B,  RG_B,  K_CNT);
      6'd25: r = ins(OP_MUL,   RG_R,  RG_R,  RG_B,  K_CNT);
      6'd26: r = ins(OP_LDK,   RG_K,  RG_N,  RG_N,  K_NM2);
      6'd27: r = ins(OP_MUL,   RG_K,  RG_K,  RG_K,  K_CNT);
      6'd28: r = ins(OP_MUL,   RG_R,  RG_R,  RG_K,  K_CNT);
      6'd29: r = ins(OP_LDK,   RG_D,  RG_N,  RG_N,  K_D);
      6'd30: r = ins(OP_MUL,   RG_D,  RG_D,  RG_D,  K_CNT);
      6'd31: r = ins(OP_MUL,   RG_T,  RG_R,  RG_D,  K_CNT);
      6'd32: r = ins(OP_QTEST, RG_T,  RG_T,  RG_L,  K_CNT);
      default: r = ins(OP_NOP, RG_N,  RG_N,  RG_N,  K_CNT);
    endcase
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      cmd_q   <= '0;
      ready_q <= 1'b1;
      pc_q    <= '0;
      bit_q   <= '0;
      res_q   <= ST_VALID;
    end else begin
      cmd_q.start <= 1'b0;
      case (state_q)
        C_IDLE: begin
          if (in_accept_i && in_last_i) begin
            state_q <= C_FIN;
            ready_q <= 1'b0;
          end
        end
        C_FIN: begin
          pc_q  <= '0;
          bit_q <= BIT_W'(Q_W - 1);
          if (stat_i.ovf) begin
            res_q   <= ST_OVF;
            state_q <= C_OUTW;
          end else if (stat_i.few) begin
            res_q   <= ST_FEW;
            state_q <= C_OUTW;
          end else begin
            state_q <= C_ISSUE;
          end
        end
        C_ISSUE: begin
          cmd_q.start  <= 1'b1;
          cmd_q.ins    <= rom(pc_q);
          cmd_q.bitpos <= bit_q;
          state_q      <= C_WAIT;
        end
        C_WAIT: begin
          if (stat_i.done) begin
            if (pc_q == PC_TESTB && stat_i.bnp) begin
              res_q   <= ST_ZVAR;
              state_q <= C_OUTW;
            end else if (pc_q == PC_LAST) begin
              if (bit_q == '0) begin
                res_q   <= ST_VALID;
                state_q <= C_OUTW;
              end else begin
                bit_q   <= bit_q - BIT_W'(1);
                pc_q    <= PC_LOOP;
                state_q <= C_ISSUE;
              end
            end else begin
              pc_q    <= pc_q + 6'd1;
              state_q <= C_ISSUE;
            end
          end
        end
        C_OUTW: begin
          if (!stat_i.out_full) begin
            cmd_q.start  <= 1'b1;
            cmd_q.ins    <= ins(OP_OUT, RG_N, RG_N, RG_N, K_CNT);
            cmd_q.status <= res_q;
            state_q      <= C_OUTD;
          end
        end
        C_OUTD: begin
          if (stat_i.done) begin
            state_q <= C_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  assign cmd_o      = cmd_q;
  assign in_ready_o = ready_q;

endmodule
